// ===== rtl/drp_pkg.sv =====
// Shared constants, types and helpers of the dated rate floor lookup.
package drp_pkg;

  // Table size and field widths.
  localparam int TableDepth   = 1024;
  localparam int CountWidth   = $clog2(TableDepth + 1);
  localparam int YearWidth    = 14;
  localparam int MonthWidth   = 4;
  localparam int DayWidth     = 5;
  localparam int KeyWidth     = YearWidth + MonthWidth + DayWidth;
  localparam int RateWidth    = 32;
  localparam int AmountWidth  = 32;
  localparam int LimitWidth   = 31;
  localparam int ProdWidth    = RateWidth + LimitWidth;
  localparam int ProductWidth = 42;
  localparam int StatusWidth  = 3;
  localparam int FracShift    = 16;

  // Date limits and the default amount limit (1000.0 in Q15.16).
  localparam int MonthMax   = 12;
  localparam int DayMax     = 31;
  localparam int LimitReset = 65536000;

  // Registered OR tree that gathers one flag and one rate across the row of cells.
  localparam int TreeLevels  = ($clog2(TableDepth) + 1) / 2;
  localparam int TreeLeaves  = 1 << (2 * TreeLevels);
  localparam int RedCntWidth = $clog2(TreeLevels + 1);

  // Result status codes.
  typedef enum logic [StatusWidth-1:0] {
    StOk       = 3'd0,
    StBadDate  = 3'd1,
    StNegative = 3'd2,
    StTooLarge = 3'd3,
    StNoRate   = 3'd4,
    StStored   = 3'd5,
    StFull     = 3'd6
  } status_e;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                cmp;
    logic                ins;
    logic                upd;
    logic                query;
    logic [KeyWidth:0]   cmp_key;
    logic [KeyWidth-1:0] key;
    logic [RateWidth-1:0] rate;
  } cmd_t;

  // What a cell hands to its right neighbor.
  typedef struct packed {
    logic                 lt;
    logic [KeyWidth-1:0]  key;
    logic [RateWidth-1:0] rate;
  } link_t;

  // One leaf or node of the reduction tree.
  typedef struct packed {
    logic                 flag;
    logic [RateWidth-1:0] rate;
  } red_t;

  // Offset of a registered tree level (from 1) in the flat node array.
  function automatic int tree_base(input int level);
    int base;
    base = 0;
    for (int j = 1; j < level; j++) begin
      base += TreeLeaves >> (2 * j);
    end
    return base;
  endfunction

  localparam int NodeCount = tree_base(TreeLevels + 1);

endpackage

// ===== rtl/drp_cell.sv =====
// One cell of the sorted table: a date key, its rate and the compare flags.
module drp_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  drp_pkg::cmd_t  cmd_i,
  input  logic           occ_i,
  input  drp_pkg::link_t left_i,
  input  logic           right_lt_i,
  output drp_pkg::link_t link_o,
  output drp_pkg::red_t  red_o
);

  logic                          lt_q, lt_d;
  logic                          eq_q, eq_d;
  logic [drp_pkg::KeyWidth-1:0]  key_q, key_d;
  logic [drp_pkg::RateWidth-1:0] rate_q, rate_d;

  // Compare the held key with the broadcast key; empty cells never match.
  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (cmd_i.cmp) begin
      lt_d = occ_i && ({1'b0, key_q} < cmd_i.cmp_key);
      eq_d = occ_i && (key_q == cmd_i.key);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  // A matching cell takes the new rate. On insert, cells at or above the
  // insert point move one place right; the one whose left neighbor is still
  // below the new key takes the new entry.
  always_comb begin
    key_d  = key_q;
    rate_d = rate_q;
    if (cmd_i.upd && eq_q) begin
      rate_d = cmd_i.rate;
    end else if (cmd_i.ins && !lt_q) begin
      if (left_i.lt) begin
        key_d  = cmd_i.key;
        rate_d = cmd_i.rate;
      end else begin
        key_d  = left_i.key;
        rate_d = left_i.rate;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    rate_q <= rate_d;
  end

  assign link_o.lt   = lt_q;
  assign link_o.key  = key_q;
  assign link_o.rate = rate_q;

  // A query hits the last cell not after the date; a load reports an exact match.
  always_comb begin
    red_o.flag = cmd_i.query ? (lt_q && !right_lt_i) : eq_q;
    red_o.rate = red_o.flag ? rate_q : '0;
  end

endmodule

// ===== rtl/drp_tree.sv =====
// Registered four-way OR tree that gathers the hit flag and rate of the cell row.
module drp_tree (
  input  logic          clk_i,
  input  drp_pkg::red_t leaf_i [drp_pkg::TableDepth],
  output drp_pkg::red_t root_o
);

  drp_pkg::red_t leaf_w [drp_pkg::TreeLeaves];
  drp_pkg::red_t node_q [drp_pkg::NodeCount];

  // Pad the row to a power of four with empty leaves.
  for (genvar j = 0; j < drp_pkg::TreeLeaves; j++) begin : g_leaf
    if (j < drp_pkg::TableDepth) begin : g_used
      assign leaf_w[j] = leaf_i[j];
    end else begin : g_pad
      assign leaf_w[j] = '0;
    end
  end

  // Each level ORs four children into one register.
  for (genvar l = 1; l <= drp_pkg::TreeLevels; l++) begin : g_level
    localparam int Nodes = drp_pkg::TreeLeaves >> (2 * l);
    localparam int Base  = drp_pkg::tree_base(l);
    localparam int Prev  = drp_pkg::tree_base(l - 1);
    for (genvar n = 0; n < Nodes; n++) begin : g_node
      if (l == 1) begin : g_first
        always_ff @(posedge clk_i) begin
          node_q[Base + n] <= leaf_w[4*n] | leaf_w[4*n + 1] |
                              leaf_w[4*n + 2] | leaf_w[4*n + 3];
        end
      end else begin : g_upper
        always_ff @(posedge clk_i) begin
          node_q[Base + n] <= node_q[Prev + 4*n] | node_q[Prev + 4*n + 1] |
                              node_q[Prev + 4*n + 2] | node_q[Prev + 4*n + 3];
        end
      end
    end
  end

  assign root_o = node_q[drp_pkg::tree_base(drp_pkg::TreeLevels)];

endmodule

// ===== rtl/dated_rate_floor_lookup.sv =====
// Top level of the dated rate floor lookup: sequencer, row of cells and reduction tree.
//
// Each item passes from the accepting edge through the compare, reduction,
// apply and output states to its result cycle, and a new item is taken in
// the cycle that shows the previous result; a query rejected by the date or
// amount checks goes straight from idle to the output state. The reduction
// state waits on the registered four-way OR tree that gathers the hit flag
// and rate from the row of cells, one tree level per cycle, while compare
// and insert each act on all cells in parallel. The result is shown for
// exactly one cycle with done_o high and the receiver cannot stall it. The
// amount limit is written through the cfg channel while busy is low.
module dated_rate_floor_lookup (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode_i,
  input  logic [drp_pkg::YearWidth-1:0]     year_i,
  input  logic [drp_pkg::MonthWidth-1:0]    month_i,
  input  logic [drp_pkg::DayWidth-1:0]      day_i,
  input  logic [drp_pkg::RateWidth-1:0]     rate_in_i,
  input  logic signed [drp_pkg::AmountWidth-1:0] amount_i,
  output logic                              done_o,
  output logic [drp_pkg::StatusWidth-1:0]   status_o,
  output logic [drp_pkg::ProductWidth-1:0]  product_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [drp_pkg::LimitWidth-1:0]    cfg_data_i
);

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SCmp   = 5'b00010,
    SRed   = 5'b00100,
    SApply = 5'b01000,
    SOut   = 5'b10000
  } state_e;

  state_e                             state_q, state_d;
  logic [drp_pkg::CountWidth-1:0]     count_q, count_d;
  logic [drp_pkg::RedCntWidth-1:0]    red_cnt_q, red_cnt_d;
  logic [drp_pkg::LimitWidth-1:0]     limit_q, limit_d;
  drp_pkg::status_e                   st_q, st_d;
  logic                               done_q, done_d;
  logic [drp_pkg::StatusWidth-1:0]    status_q, status_d;
  logic [drp_pkg::ProductWidth-1:0]   product_q, product_d;

  logic                               mode_q, mode_d;
  logic [drp_pkg::KeyWidth-1:0]       key_q, key_d;
  logic [drp_pkg::RateWidth-1:0]      rate_q, rate_d;
  logic [drp_pkg::LimitWidth-1:0]     amt_q, amt_d;
  logic [drp_pkg::ProdWidth-1:0]      prod_q, prod_d;

  logic                               bad_date;
  logic                               pre_err;
  drp_pkg::status_e                   pre_status;
  logic [drp_pkg::ProdWidth-FracShift-1:0] full_prod;
  logic [drp_pkg::ProductWidth-1:0]   sat_prod;

  logic                               cmd_ins;
  logic                               cmd_upd;
  drp_pkg::cmd_t                      cmd;
  drp_pkg::link_t                     link_w [drp_pkg::TableDepth];
  drp_pkg::red_t                      red_w  [drp_pkg::TableDepth];
  drp_pkg::red_t                      root;
  logic [drp_pkg::TableDepth-1:0]     occ;

  localparam int FracShift = drp_pkg::FracShift;

  assign busy        = (state_q != SIdle);
  assign cfg_ready_o = (state_q == SIdle);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign product_o   = product_q;

  // Query checks, in priority order: date, sign, limit.
  always_comb begin
    bad_date = (month_i < drp_pkg::MonthWidth'(1)) ||
               (month_i > drp_pkg::MonthWidth'(drp_pkg::MonthMax)) ||
               (day_i < drp_pkg::DayWidth'(1)) ||
               (day_i > drp_pkg::DayWidth'(drp_pkg::DayMax));
    pre_err    = 1'b1;
    pre_status = drp_pkg::StOk;
    priority if (bad_date) begin
      pre_status = drp_pkg::StBadDate;
    end else if (amount_i[drp_pkg::AmountWidth-1]) begin
      pre_status = drp_pkg::StNegative;
    end else if (amount_i[drp_pkg::LimitWidth-1:0] > limit_q) begin
      pre_status = drp_pkg::StTooLarge;
    end else begin
      pre_err = 1'b0;
    end
  end

  // Drop the fraction and saturate to the product width.
  assign full_prod = prod_q[drp_pkg::ProdWidth-1:FracShift];
  assign sat_prod  = (|full_prod[drp_pkg::ProdWidth-FracShift-1:drp_pkg::ProductWidth])
                     ? '1 : full_prod[drp_pkg::ProductWidth-1:0];

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    red_cnt_d = red_cnt_q;
    limit_d   = limit_q;
    st_d      = st_q;
    done_d    = 1'b0;
    status_d  = status_q;
    product_d = product_q;
    mode_d    = mode_q;
    key_d     = key_q;
    rate_d    = rate_q;
    amt_d     = amt_q;
    prod_d    = prod_q;
    cmd_ins   = 1'b0;
    cmd_upd   = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      limit_d = cfg_data_i;
    end

    unique case (state_q)
      SIdle: begin
        if (start) begin
          mode_d = mode_i;
          key_d  = {year_i, month_i, day_i};
          rate_d = rate_in_i;
          amt_d  = amount_i[drp_pkg::LimitWidth-1:0];
          if (mode_i && pre_err) begin
            st_d    = pre_status;
            state_d = SOut;
          end else begin
            state_d = SCmp;
          end
        end
      end
      SCmp: begin
        red_cnt_d = '0;
        state_d   = SRed;
      end
      SRed: begin
        red_cnt_d = red_cnt_q + 1'b1;
        if (red_cnt_q == drp_pkg::RedCntWidth'(drp_pkg::TreeLevels - 1)) begin
          state_d = SApply;
        end
      end
      SApply: begin
        state_d = SOut;
        if (mode_q) begin
          if (root.flag) begin
            st_d   = drp_pkg::StOk;
            prod_d = root.rate * amt_q;
          end else begin
            st_d = drp_pkg::StNoRate;
          end
        end else if (root.flag) begin
          cmd_upd = 1'b1;
          st_d    = drp_pkg::StStored;
        end else if (count_q == drp_pkg::CountWidth'(drp_pkg::TableDepth)) begin
          st_d = drp_pkg::StFull;
        end else begin
          cmd_ins = 1'b1;
          count_d = count_q + 1'b1;
          st_d    = drp_pkg::StStored;
        end
      end
      SOut: begin
        done_d    = 1'b1;
        status_d  = st_q;
        product_d = (st_q == drp_pkg::StOk) ? sat_prod : '0;
        state_d   = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      count_q   <= '0;
      red_cnt_q <= '0;
      limit_q   <= drp_pkg::LimitWidth'(drp_pkg::LimitReset);
      st_q      <= drp_pkg::StOk;
      done_q    <= 1'b0;
      status_q  <= '0;
      product_q <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      red_cnt_q <= red_cnt_d;
      limit_q   <= limit_d;
      st_q      <= st_d;
      done_q    <= done_d;
      status_q  <= status_d;
      product_q <= product_d;
    end
  end

  // Item payload and product.
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    key_q  <= key_d;
    rate_q <= rate_d;
    amt_q  <= amt_d;
    prod_q <= prod_d;
  end

  // Broadcast to the cells; a query compares against the next key so that
  // "below" means "not after the date".
  assign cmd.cmp     = (state_q == SCmp);
  assign cmd.ins     = cmd_ins;
  assign cmd.upd     = cmd_upd;
  assign cmd.query   = mode_q;
  assign cmd.cmp_key = mode_q ? ({1'b0, key_q} + 1'b1) : {1'b0, key_q};
  assign cmd.key     = key_q;
  assign cmd.rate    = rate_q;

  // Row of cells, each linked to its neighbors.
  for (genvar i = 0; i < drp_pkg::TableDepth; i++) begin : g_cell
    drp_pkg::link_t left_w;
    logic           right_lt_w;

    assign occ[i] = (drp_pkg::CountWidth'(i) < count_q);

    // The first cell sees a left neighbor that is below every key.
    if (i == 0) begin : g_first
      assign left_w = '{lt: 1'b1, key: '0, rate: '0};
    end else begin : g_inner
      assign left_w = link_w[i-1];
    end

    if (i == drp_pkg::TableDepth - 1) begin : g_last
      assign right_lt_w = 1'b0;
    end else begin : g_body
      assign right_lt_w = link_w[i+1].lt;
    end

    drp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .occ_i      (occ[i]),
      .left_i     (left_w),
      .right_lt_i (right_lt_w),
      .link_o     (link_w[i]),
      .red_o      (red_w[i])
    );
  end

  drp_tree u_tree (
    .clk_i  (clk_i),
    .leaf_i (red_w),
    .root_o (root)
  );

endmodule

// ===== rtl/drp_checker.sv =====
// Port-level checks of the dated rate floor lookup and their binding.
module drp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic [drp_pkg::StatusWidth-1:0]  status_o,
  input logic [drp_pkg::ProductWidth-1:0] product_o
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after an accepted item");

  // A result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // The block is free again while it shows a result.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy while a result is shown");

  // Only a successful query carries a product.
  a_product_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != drp_pkg::StOk) |-> product_o == '0)
    else $error("nonzero product with a failing status");

  // Status stays within the defined codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o <= drp_pkg::StFull)
    else $error("undefined status code");

endmodule

bind dated_rate_floor_lookup drp_checker u_drp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .status_o  (status_o),
  .product_o (product_o)
);
